// File: rtl/sts_pkg.sv
// Shared types, token and error codes, and character constants of the script token scanner.
// Used by every module of the scanner; depends on nothing.
`default_nettype none
package sts_pkg;

  localparam int OffsetBitsDefault = 32;
  localparam int MaxBraceDepthDefault = 255;
  localparam int KeywordMaxLen = 8;
  localparam int MaxTokens = 3;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_NEWLINE = 6'd1;
  localparam logic [5:0] K_NUMBER = 6'd2;
  localparam logic [5:0] K_FLOAT = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4;
  localparam logic [5:0] K_ISTRING = 6'd5;
  localparam logic [5:0] K_CHAR = 6'd6;
  localparam logic [5:0] K_IDENT = 6'd7;
  localparam logic [5:0] K_LET = 6'd8;
  localparam logic [5:0] K_PRINT = 6'd9;
  localparam logic [5:0] K_TRUE = 6'd10;
  localparam logic [5:0] K_FALSE = 6'd11;
  localparam logic [5:0] K_IF = 6'd12;
  localparam logic [5:0] K_ELIF = 6'd13;
  localparam logic [5:0] K_ELSE = 6'd14;
  localparam logic [5:0] K_WHILE = 6'd15;
  localparam logic [5:0] K_FOR = 6'd16;
  localparam logic [5:0] K_TO = 6'd17;
  localparam logic [5:0] K_IN = 6'd18;
  localparam logic [5:0] K_USE = 6'd19;
  localparam logic [5:0] K_AS = 6'd20;
  localparam logic [5:0] K_AND = 6'd21;
  localparam logic [5:0] K_OR = 6'd22;
  localparam logic [5:0] K_NOT = 6'd23;
  localparam logic [5:0] K_BREAK = 6'd24;
  localparam logic [5:0] K_CONTINUE = 6'd25;
  localparam logic [5:0] K_FN = 6'd26;
  localparam logic [5:0] K_SEND = 6'd27;
  localparam logic [5:0] K_NULL = 6'd28;
  localparam logic [5:0] K_PLUS = 6'd29;
  localparam logic [5:0] K_PLUS_PLUS = 6'd30;
  localparam logic [5:0] K_PLUS_EQ = 6'd31;
  localparam logic [5:0] K_MINUS = 6'd32;
  localparam logic [5:0] K_MINUS_MINUS = 6'd33;
  localparam logic [5:0] K_MINUS_EQ = 6'd34;
  localparam logic [5:0] K_STAR = 6'd35;
  localparam logic [5:0] K_STAR_EQ = 6'd36;
  localparam logic [5:0] K_SLASH = 6'd37;
  localparam logic [5:0] K_SLASH_EQ = 6'd38;
  localparam logic [5:0] K_PERCENT = 6'd39;
  localparam logic [5:0] K_PERCENT_EQ = 6'd40;
  localparam logic [5:0] K_LPAREN = 6'd41;
  localparam logic [5:0] K_RPAREN = 6'd42;
  localparam logic [5:0] K_LBRACE = 6'd43;
  localparam logic [5:0] K_RBRACE = 6'd44;
  localparam logic [5:0] K_LBRACKET = 6'd45;
  localparam logic [5:0] K_RBRACKET = 6'd46;
  localparam logic [5:0] K_COMMA = 6'd47;
  localparam logic [5:0] K_COLON = 6'd48;
  localparam logic [5:0] K_DOT = 6'd49;
  localparam logic [5:0] K_EQ = 6'd50;
  localparam logic [5:0] K_EQ_EQ = 6'd51;
  localparam logic [5:0] K_BANG_EQ = 6'd52;
  localparam logic [5:0] K_LESS = 6'd53;
  localparam logic [5:0] K_LESS_EQ = 6'd54;
  localparam logic [5:0] K_GREATER = 6'd55;
  localparam logic [5:0] K_GREATER_EQ = 6'd56;
  localparam logic [5:0] K_ERROR = 6'd57;

  localparam logic [3:0] E_NONE = 4'd0;
  localparam logic [3:0] E_UNTERM_STR = 4'd1;
  localparam logic [3:0] E_UNTERM_TRIPLE = 4'd2;
  localparam logic [3:0] E_UNTERM_CHAR = 4'd3;
  localparam logic [3:0] E_CHAR_CLOSE = 4'd4;
  localparam logic [3:0] E_UNTERM_ISTR = 4'd5;
  localparam logic [3:0] E_UNTERM_NESTED = 4'd6;
  localparam logic [3:0] E_UNMATCHED_BRACE = 4'd7;
  localparam logic [3:0] E_DOLLAR = 4'd8;
  localparam logic [3:0] E_UNEXPECTED = 4'd9;
  localparam logic [3:0] E_DEPTH = 4'd10;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_BSL = 8'h5C;

  typedef struct packed {
    logic [5:0]  kind;
    logic [3:0]  err;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic [63:0] value;
  } tok_t;

  typedef struct packed {
    tok_t [MaxTokens-1:0] tok;
    logic [1:0]           count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [3:0] n);
    logic [5:0] k;
    k = K_IDENT;
    if (n == 4'd3 && w == 64'("let")) k = K_LET;
    if (n == 4'd5 && w == 64'("print")) k = K_PRINT;
    if (n == 4'd4 && w == 64'("true")) k = K_TRUE;
    if (n == 4'd5 && w == 64'("false")) k = K_FALSE;
    if (n == 4'd2 && w == 64'("if")) k = K_IF;
    if (n == 4'd4 && w == 64'("elif")) k = K_ELIF;
    if (n == 4'd4 && w == 64'("else")) k = K_ELSE;
    if (n == 4'd5 && w == 64'("while")) k = K_WHILE;
    if (n == 4'd3 && w == 64'("for")) k = K_FOR;
    if (n == 4'd2 && w == 64'("to")) k = K_TO;
    if (n == 4'd2 && w == 64'("in")) k = K_IN;
    if (n == 4'd3 && w == 64'("use")) k = K_USE;
    if (n == 4'd2 && w == 64'("as")) k = K_AS;
    if (n == 4'd3 && w == 64'("and")) k = K_AND;
    if (n == 4'd2 && w == 64'("or")) k = K_OR;
    if (n == 4'd3 && w == 64'("not")) k = K_NOT;
    if (n == 4'd5 && w == 64'("break")) k = K_BREAK;
    if (n == 4'd8 && w == 64'("continue")) k = K_CONTINUE;
    if (n == 4'd2 && w == 64'("fn")) k = K_FN;
    if (n == 4'd4 && w == 64'("send")) k = K_SEND;
    if (n == 4'd4 && w == 64'("null")) k = K_NULL;
    return k;
  endfunction

endpackage
`default_nettype wire

// File: rtl/script_token_scanner_top.sv
// Top level of the script token scanner: front end, bundle queue and token sender.
// Depends on sts_pkg, sts_front, sts_fifo and sts_back.
`default_nettype none
// The scanner takes one source byte per cycle while source_byte_ready_o is high and emits
// tokens on a valid/ready channel, one token per word, with last_of_run_o marking the final
// token caused by a byte. A byte yielding two or three tokens holds the token port for one
// handshake per token, and the two-bundle queue between the scanner and the token port
// absorbs short bursts before source_byte_ready_o drops.
module script_token_scanner_top #(
  parameter int OffsetBits = sts_pkg::OffsetBitsDefault,
  parameter int MaxBraceDepth = sts_pkg::MaxBraceDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               source_byte_valid_i,
  output logic                    source_byte_ready_o,
  input  wire logic [7:0]         source_byte_i,
  output logic                    token_valid_o,
  input  wire logic               token_ready_i,
  output logic [5:0]              token_kind_o,
  output logic [3:0]              error_kind_o,
  output logic [31:0]             start_offset_o,
  output logic [31:0]             token_length_o,
  output logic [31:0]             token_line_o,
  output logic signed [63:0]      token_value_o,
  output logic                    last_of_run_o
);

  sts_pkg::bundle_t front_bundle, head;
  sts_pkg::q_status_t q_status;
  sts_pkg::tok_t tok;
  logic take, pop;

  assign source_byte_ready_o = !q_status.full;
  assign take = source_byte_valid_i && source_byte_ready_o;

  sts_front #(
    .OffsetBits(OffsetBits),
    .MaxBraceDepth(MaxBraceDepth)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .byte_i(source_byte_i),
    .bundle_o(front_bundle)
  );

  sts_fifo u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(take && front_bundle.count != 2'd0),
    .data_i(front_bundle),
    .pop_i(pop),
    .data_o(head),
    .status_o(q_status)
  );

  sts_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .status_i(q_status),
    .ready_i(token_ready_i),
    .valid_o(token_valid_o),
    .tok_o(tok),
    .last_o(last_of_run_o),
    .pop_o(pop)
  );

  assign token_kind_o = tok.kind;
  assign error_kind_o = tok.err;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign token_line_o = tok.line;
  assign token_value_o = tok.value;

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty)) else $error("queue both full and empty");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o |-> token_kind_o <= sts_pkg::K_ERROR) else $error("bad token kind");
  a_err_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o && token_kind_o != sts_pkg::K_ERROR |-> error_kind_o == sts_pkg::E_NONE)
    else $error("error code on a non-error token");
`endif

endmodule
`default_nettype wire

// File: rtl/sts_front.sv
// Front end of the scanner: takes one source byte a cycle while take_i is high and classifies
// it into up to three tokens. Depends on sts_pkg.
`default_nettype none
module sts_front #(
  parameter int OffsetBits = sts_pkg::OffsetBitsDefault,
  parameter int MaxBraceDepth = sts_pkg::MaxBraceDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  wire logic [7:0]     byte_i,
  output sts_pkg::bundle_t    bundle_o
);

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_NEWLINE, M_IDENT, M_NUM, M_NUM_DOT, M_FLOAT,
    M_STR_Q1, M_STR_Q2, M_STR, M_STR_ESC, M_TRIPLE, M_CHAR_OPEN,
    M_CHAR_ESC, M_CHAR_CLOSE, M_DOLLAR, M_INTERP, M_INTERP_ESC,
    M_NESTED, M_NESTED_ESC, M_OP
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [OffsetBits-1:0] begin_ofs;
    logic [31:0]           line;
    logic [63:0]           num;
    logic [63:0]           word;
    logic [3:0]            wlen;
    logic [7:0]            depth;
    logic [1:0]            look;
    logic [7:0]            lit;
    logic                  restart;
  } scan_st_t;

  localparam scan_st_t ScanReset = '{mode: M_IDLE, begin_ofs: '0, line: 32'd1, num: '0,
                                     word: '0, wlen: '0, depth: '0, look: '0, lit: '0,
                                     restart: 1'b0};

  scan_st_t st_q, st_d;
  logic [OffsetBits-1:0] pos_q, pos_d;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void emit(inout sts_pkg::bundle_t b, input logic [5:0] kind,
                               input logic [3:0] err, input logic [OffsetBits-1:0] start,
                               input logic [OffsetBits-1:0] len, input logic [63:0] value,
                               input logic [31:0] line);
    if (b.count < 2'(sts_pkg::MaxTokens)) begin
      b.tok[b.count].kind = kind;
      b.tok[b.count].err = err;
      b.tok[b.count].start = 32'(start);
      b.tok[b.count].len = 32'(len);
      b.tok[b.count].line = line;
      b.tok[b.count].value = value;
      b.count = b.count + 2'd1;
    end
  endfunction

  function automatic void fail(inout scan_st_t s, inout sts_pkg::bundle_t b,
                               input logic [3:0] err, input logic [OffsetBits-1:0] end_ofs);
    emit(b, sts_pkg::K_ERROR, err, s.begin_ofs, end_ofs - s.begin_ofs, 64'd0, s.line);
    s.mode = M_IDLE;
  endfunction

  function automatic void scan_pass(input logic [7:0] c, input logic [OffsetBits-1:0] p,
                                    inout scan_st_t s, inout sts_pkg::bundle_t b,
                                    output logic taken);
    logic [OffsetBits-1:0] nx;
    logic [5:0] single, twin, eq;
    nx = p + OffsetBits'(1);
    single = sts_pkg::K_ERROR;
    twin = sts_pkg::K_EOF;
    eq = sts_pkg::K_BANG_EQ;
    taken = 1'b1;
    unique case (s.mode)
      M_IDLE: begin
        s.begin_ofs = p;
        case (c)
          sts_pkg::CH_NUL: begin
            emit(b, sts_pkg::K_EOF, sts_pkg::E_NONE, p, '0, 64'd0, s.line);
            s.restart = 1'b1;
          end
          " ", sts_pkg::CH_CR, sts_pkg::CH_TAB: ;
          "#": s.mode = M_COMMENT;
          sts_pkg::CH_LF: begin
            s.line = s.line + 32'd1;
            s.mode = M_NEWLINE;
          end
          sts_pkg::CH_DQ: s.mode = M_STR_Q1;
          "$": s.mode = M_DOLLAR;
          sts_pkg::CH_SQ: s.mode = M_CHAR_OPEN;
          "(": emit(b, sts_pkg::K_LPAREN, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          ")": emit(b, sts_pkg::K_RPAREN, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          "{": emit(b, sts_pkg::K_LBRACE, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          "}": emit(b, sts_pkg::K_RBRACE, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          "[": emit(b, sts_pkg::K_LBRACKET, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          "]": emit(b, sts_pkg::K_RBRACKET, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          ",": emit(b, sts_pkg::K_COMMA, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          ":": emit(b, sts_pkg::K_COLON, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          ".": emit(b, sts_pkg::K_DOT, sts_pkg::E_NONE, p, OffsetBits'(1), 64'd0, s.line);
          "+", "-", "*", "/", "%", "=", "<", ">", "!": begin
            s.lit = c;
            s.mode = M_OP;
          end
          default: begin
            if (is_digit(c)) begin
              s.num = 64'(c - "0");
              s.mode = M_NUM;
            end else if (is_alpha(c) || c == "_") begin
              s.word = 64'(c);
              s.wlen = 4'd1;
              s.mode = M_IDENT;
            end else begin
              emit(b, sts_pkg::K_ERROR, sts_pkg::E_UNEXPECTED, p, OffsetBits'(1), 64'd0,
                   s.line);
            end
          end
        endcase
      end
      M_OP: begin
        case (s.lit)
          "+": begin
            single = sts_pkg::K_PLUS; twin = sts_pkg::K_PLUS_PLUS; eq = sts_pkg::K_PLUS_EQ;
          end
          "-": begin
            single = sts_pkg::K_MINUS; twin = sts_pkg::K_MINUS_MINUS;
            eq = sts_pkg::K_MINUS_EQ;
          end
          "*": begin single = sts_pkg::K_STAR; eq = sts_pkg::K_STAR_EQ; end
          "/": begin single = sts_pkg::K_SLASH; eq = sts_pkg::K_SLASH_EQ; end
          "%": begin single = sts_pkg::K_PERCENT; eq = sts_pkg::K_PERCENT_EQ; end
          "=": begin single = sts_pkg::K_EQ; eq = sts_pkg::K_EQ_EQ; end
          "<": begin single = sts_pkg::K_LESS; eq = sts_pkg::K_LESS_EQ; end
          ">": begin single = sts_pkg::K_GREATER; eq = sts_pkg::K_GREATER_EQ; end
          default: ;
        endcase
        s.mode = M_IDLE;
        if (twin != sts_pkg::K_EOF && c == s.lit) begin
          emit(b, twin, sts_pkg::E_NONE, s.begin_ofs, OffsetBits'(2), 64'd0, s.line);
        end else if (c == "=") begin
          emit(b, eq, sts_pkg::E_NONE, s.begin_ofs, OffsetBits'(2), 64'd0, s.line);
        end else begin
          emit(b, single,
               (single == sts_pkg::K_ERROR) ? sts_pkg::E_UNEXPECTED : sts_pkg::E_NONE,
               s.begin_ofs, p - s.begin_ofs, 64'd0, s.line);
          taken = 1'b0;
        end
      end
      M_COMMENT: begin
        if (c == sts_pkg::CH_LF || c == sts_pkg::CH_NUL) begin
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_NEWLINE: begin
        if (c == sts_pkg::CH_LF) begin
          s.line = s.line + 32'd1;
        end else if (c != sts_pkg::CH_CR) begin
          emit(b, sts_pkg::K_NEWLINE, sts_pkg::E_NONE, s.begin_ofs, p - s.begin_ofs, 64'd0,
               s.line);
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (s.wlen < 4'(sts_pkg::KeywordMaxLen)) begin
            s.word = {s.word[55:0], c};
            s.wlen = s.wlen + 4'd1;
          end else begin
            s.wlen = 4'(sts_pkg::KeywordMaxLen + 1);
          end
        end else begin
          emit(b, sts_pkg::word_kind(s.word, s.wlen), sts_pkg::E_NONE, s.begin_ofs,
               p - s.begin_ofs, 64'd0, s.line);
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          s.num = {s.num[60:0], 3'b000} + {s.num[62:0], 1'b0} + 64'(c - "0");
        end else if (c == ".") begin
          s.mode = M_NUM_DOT;
        end else begin
          emit(b, sts_pkg::K_NUMBER, sts_pkg::E_NONE, s.begin_ofs, p - s.begin_ofs, s.num,
               s.line);
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_NUM_DOT: begin
        if (is_digit(c)) begin
          s.mode = M_FLOAT;
        end else begin
          emit(b, sts_pkg::K_NUMBER, sts_pkg::E_NONE, s.begin_ofs,
               p - OffsetBits'(1) - s.begin_ofs, s.num, s.line);
          emit(b, sts_pkg::K_DOT, sts_pkg::E_NONE, p - OffsetBits'(1), OffsetBits'(1), 64'd0,
               s.line);
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_FLOAT: begin
        if (!is_digit(c)) begin
          emit(b, sts_pkg::K_FLOAT, sts_pkg::E_NONE, s.begin_ofs, p - s.begin_ofs, 64'd0,
               s.line);
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_STR_Q1: begin
        if (c == sts_pkg::CH_DQ) begin
          s.mode = M_STR_Q2;
        end else begin
          s.mode = M_STR;
          taken = 1'b0;
        end
      end
      M_STR_Q2: begin
        if (c == sts_pkg::CH_DQ) begin
          s.mode = M_TRIPLE;
          s.look = 2'd0;
        end else begin
          emit(b, sts_pkg::K_STRING, sts_pkg::E_NONE, s.begin_ofs, OffsetBits'(2), 64'd0,
               s.line);
          s.mode = M_IDLE;
          taken = 1'b0;
        end
      end
      M_STR: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_STR, p);
          taken = 1'b0;
        end else if (c == sts_pkg::CH_LF) begin
          s.line = s.line + 32'd1;
        end else if (c == sts_pkg::CH_BSL) begin
          s.mode = M_STR_ESC;
        end else if (c == sts_pkg::CH_DQ) begin
          emit(b, sts_pkg::K_STRING, sts_pkg::E_NONE, s.begin_ofs, nx - s.begin_ofs, 64'd0,
               s.line);
          s.mode = M_IDLE;
        end
      end
      M_STR_ESC: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_STR, p);
          taken = 1'b0;
        end else begin
          s.mode = M_STR;
        end
      end
      M_TRIPLE: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_TRIPLE, p);
          taken = 1'b0;
        end else if (c == sts_pkg::CH_DQ) begin
          if (s.look >= 2'd2) begin
            emit(b, sts_pkg::K_STRING, sts_pkg::E_NONE, s.begin_ofs + OffsetBits'(3),
                 p - OffsetBits'(2) - (s.begin_ofs + OffsetBits'(3)), 64'd1, s.line);
            s.look = 2'd0;
            s.mode = M_IDLE;
          end else begin
            s.look = s.look + 2'd1;
          end
        end else begin
          s.look = 2'd0;
          if (c == sts_pkg::CH_LF) s.line = s.line + 32'd1;
        end
      end
      M_CHAR_OPEN: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_CHAR, p);
          taken = 1'b0;
        end else if (c == sts_pkg::CH_BSL) begin
          s.mode = M_CHAR_ESC;
        end else begin
          s.lit = c;
          s.mode = M_CHAR_CLOSE;
        end
      end
      M_CHAR_ESC: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_CHAR, p);
          taken = 1'b0;
        end else begin
          s.lit = (c == "n") ? sts_pkg::CH_LF : ((c == "t") ? sts_pkg::CH_TAB : c);
          s.mode = M_CHAR_CLOSE;
        end
      end
      M_CHAR_CLOSE: begin
        if (c == sts_pkg::CH_SQ) begin
          emit(b, sts_pkg::K_CHAR, sts_pkg::E_NONE, s.begin_ofs, nx - s.begin_ofs,
               64'(s.lit), s.line);
          s.mode = M_IDLE;
        end else begin
          fail(s, b, sts_pkg::E_CHAR_CLOSE, p);
          taken = 1'b0;
        end
      end
      M_DOLLAR: begin
        if (c == sts_pkg::CH_DQ) begin
          s.mode = M_INTERP;
          s.depth = 8'd0;
        end else begin
          fail(s, b, sts_pkg::E_DOLLAR, p);
          taken = 1'b0;
        end
      end
      M_INTERP: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_ISTR, p);
          taken = 1'b0;
        end else if (c == sts_pkg::CH_BSL) begin
          s.mode = M_INTERP_ESC;
        end else if (c == sts_pkg::CH_DQ) begin
          if (s.depth == 8'd0) begin
            emit(b, sts_pkg::K_ISTRING, sts_pkg::E_NONE, s.begin_ofs + OffsetBits'(2),
                 p - (s.begin_ofs + OffsetBits'(2)), 64'd0, s.line);
            s.mode = M_IDLE;
          end else begin
            s.mode = M_NESTED;
          end
        end else if (c == "{") begin
          if (s.depth >= 8'(MaxBraceDepth)) fail(s, b, sts_pkg::E_DEPTH, nx);
          else s.depth = s.depth + 8'd1;
        end else if (c == "}") begin
          if (s.depth == 8'd0) begin
            fail(s, b, sts_pkg::E_UNMATCHED_BRACE, p);
            taken = 1'b0;
          end else begin
            s.depth = s.depth - 8'd1;
          end
        end else if (c == sts_pkg::CH_LF) begin
          s.line = s.line + 32'd1;
        end
      end
      M_INTERP_ESC: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_ISTR, p);
          taken = 1'b0;
        end else begin
          s.mode = M_INTERP;
        end
      end
      M_NESTED: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_NESTED, p);
          taken = 1'b0;
        end else if (c == sts_pkg::CH_LF) begin
          s.line = s.line + 32'd1;
        end else if (c == sts_pkg::CH_BSL) begin
          s.mode = M_NESTED_ESC;
        end else if (c == sts_pkg::CH_DQ) begin
          s.mode = M_INTERP;
        end
      end
      M_NESTED_ESC: begin
        if (c == sts_pkg::CH_NUL) begin
          fail(s, b, sts_pkg::E_UNTERM_NESTED, p);
          taken = 1'b0;
        end else begin
          s.mode = M_NESTED;
        end
      end
      default: begin
        s.mode = M_IDLE;
        taken = 1'b0;
      end
    endcase
  endfunction

  // A byte that only ends a token is scanned again; at most three passes can occur.
  always_comb begin
    scan_st_t s;
    sts_pkg::bundle_t b;
    logic taken, t;
    s = st_q;
    s.restart = 1'b0;
    b = '0;
    taken = 1'b0;
    t = 1'b0;
    for (int i = 0; i < sts_pkg::MaxTokens; i++) begin
      if (!taken) begin
        scan_pass(byte_i, pos_q, s, b, t);
        taken = t;
      end
    end
    pos_d = pos_q + OffsetBits'(1);
    if (s.restart) begin
      s = ScanReset;
      pos_d = '0;
    end
    st_d = s;
    bundle_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ScanReset;
      pos_q <= '0;
    end else if (take_i) begin
      st_q <= st_d;
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sts_fifo.sv
// Two-entry queue of token bundles between the scanner front end and the token sender.
// Depends on sts_pkg.
`default_nettype none
module sts_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  sts_pkg::bundle_t    data_i,
  input  wire logic           pop_i,
  output sts_pkg::bundle_t    data_o,
  output sts_pkg::q_status_t  status_o
);

  sts_pkg::bundle_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign data_o = mem_q[rd_q];
  assign status_o.full = cnt_q == 2'd2;
  assign status_o.empty = cnt_q == 2'd0;

endmodule
`default_nettype wire

// File: rtl/sts_back.sv
// Token sender: walks the tokens of the bundle at the queue head, one word per handshake.
// Depends on sts_pkg.
`default_nettype none
module sts_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  sts_pkg::bundle_t    head_i,
  input  sts_pkg::q_status_t  status_i,
  input  wire logic           ready_i,
  output logic                valid_o,
  output sts_pkg::tok_t       tok_o,
  output logic                last_o,
  output logic                pop_o
);

  logic [1:0] idx_q;

  assign valid_o = !status_i.empty;
  assign tok_o = head_i.tok[idx_q];
  assign last_o = idx_q == head_i.count - 2'd1;
  assign pop_o = valid_o && ready_i && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (valid_o && ready_i) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule
`default_nettype wire
